// ===== hdl/psw_pkg.sv =====
package psw_pkg;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_FULL      = 2'd1,
        VERDICT_RATE      = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        REG_CAPACITY      = 3'd0,
        REG_WINDOW_LENGTH = 3'd1,
        REG_WINDOW_LIMIT  = 3'd2,
        REG_DRAIN_RATE    = 3'd3,
        REG_SAMPLE_INT    = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DREAD,
        B_DCMP,
        B_WREAD,
        B_WCMP,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [6:0]  capacity_in_use;
        logic [31:0] window_length;
        logic [6:0]  window_limit;
        logic [31:0] sample_interval;
    } cfg_t;

    localparam logic [6:0]  RST_CAPACITY     = 7'd64;
    localparam logic [31:0] RST_WINDOW_LEN   = 32'd1000;
    localparam logic [6:0]  RST_WINDOW_LIMIT = 7'd64;
    localparam logic [15:0] RST_DRAIN_RATE   = 16'd1;
    localparam logic [31:0] RST_SAMPLE_INT   = 32'd50;

endpackage

// ===== hdl/psw_if.sv =====
interface psw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] arrival_time;
    logic [15:0] packet_bytes;

    modport source (output valid, output arrival_time, output packet_bytes, input ready);
    modport sink (input valid, input arrival_time, input packet_bytes, output ready);
endinterface

interface psw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] accepted_total;
    logic [31:0] full_reject_total;
    logic [31:0] rate_reject_total;
    logic [6:0]  occupancy;
    logic        sample_taken;

    modport source (output valid, output verdict, output accepted_total,
                    output full_reject_total, output rate_reject_total,
                    output occupancy, output sample_taken, input ready);
    modport sink (input valid, input verdict, input accepted_total,
                  input full_reject_total, input rate_reject_total,
                  input occupancy, input sample_taken, output ready);
endinterface

// ===== hdl/psw_ram.sv =====
module psw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== hdl/psw_fifo.sv =====
module psw_fifo #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             nonempty,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push && !full)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop && nonempty)
        begin
            rptr_next = ~rptr_reg;
        end
        case ({push && !full, pop && nonempty})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end
endmodule

// ===== hdl/psw_front.sv =====
module psw_front
    import psw_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    localparam int DIVW = 16 + FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     drain_rate,
    psw_in_if.sink          pkt_in,
    output logic            push,
    output logic [31:0]     arrival,
    output logic [DIVW-1:0] duration,
    input  logic            fifo_full
);
    localparam int CNTW = $clog2(DIVW + 1);

    front_state_t    state_reg, state_next;
    logic [31:0]     arr_reg, arr_next;
    logic [DIVW-1:0] quo_reg, quo_next;
    logic [15:0]     rem_reg, rem_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [15:0]     divisor;
    logic [16:0]     trial;
    logic            ge;

    // zero rate divides as one
    assign divisor  = (drain_rate == 16'd0) ? 16'd1 : drain_rate;
    assign trial    = {rem_reg, quo_reg[DIVW-1]};
    assign ge       = (trial >= {1'b0, divisor});
    assign arrival  = arr_reg;
    assign duration = quo_reg;

    always_comb
    begin
        state_next   = state_reg;
        arr_next     = arr_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        pkt_in.ready = 1'b0;
        push         = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                pkt_in.ready = 1'b1;
                if (pkt_in.valid)
                begin
                    arr_next   = pkt_in.arrival_time;
                    quo_next   = DIVW'(pkt_in.packet_bytes) << FRAC_BITS;
                    rem_next   = 16'd0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                // one quotient bit per cycle
                quo_next = {quo_reg[DIVW-2:0], ge};
                rem_next = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DIVW - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg <= arr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
endmodule

// ===== hdl/psw_back.sv =====
module psw_back
    import psw_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int WINDOW_DEPTH = 64,
    parameter int FRAC_BITS    = 16,
    parameter int TIME_BITS    = 32,
    localparam int DIVW = 16 + FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            fifo_nonempty,
    input  logic [31:0]     item_arrival,
    input  logic [DIVW-1:0] item_duration,
    output logic            fifo_pop,
    psw_out_if.source       res_out
);
    localparam int DW  = TIME_BITS + FRAC_BITS;
    localparam int MW  = (32 + FRAC_BITS > DW) ? 32 + FRAC_BITS : DW;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WAW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int WCW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [DW-1:0] DEP_MAX = {DW{1'b1}};

    back_state_t     state_reg, state_next;
    logic [31:0]     arr_reg, arr_next;
    logic [DIVW-1:0] dur_reg, dur_next;
    logic [QAW-1:0]  dhead_reg, dhead_next;
    logic [QCW-1:0]  dcount_reg, dcount_next;
    logic [DW-1:0]   last_dep_reg, last_dep_next;
    logic [WAW-1:0]  whead_reg, whead_next;
    logic [WCW-1:0]  wcount_reg, wcount_next;
    logic [31:0]     acc_reg, acc_next;
    logic [31:0]     fullc_reg, fullc_next;
    logic [31:0]     ratec_reg, ratec_next;
    logic [31:0]     last_sample_reg, last_sample_next;
    logic            first_reg, first_next;
    verdict_t        verdict_reg, verdict_next;

    logic            out_valid_reg, out_valid_next;
    verdict_t        o_verdict_reg, o_verdict_next;
    logic [31:0]     o_acc_reg, o_acc_next;
    logic [31:0]     o_full_reg, o_full_next;
    logic [31:0]     o_rate_reg, o_rate_next;
    logic [6:0]      o_occ_reg, o_occ_next;
    logic            o_sample_reg, o_sample_next;

    logic [MW-1:0]   arr_ext;
    logic [DW-1:0]   arr_fx;
    logic [DW-1:0]   dep_rd;
    logic [31:0]     win_rd;
    logic            dep_we, win_we;
    logic [QCW:0]    dtail_sum;
    logic [QAW-1:0]  dtail;
    logic [WCW:0]    wtail_sum;
    logic [WAW-1:0]  wtail;
    logic [15:0]     cap_eff, lim_eff;
    logic            full, room;
    logic [31:0]     win_edge;
    logic [DW-1:0]   base;
    logic [DW:0]     dep_sum;
    logic [DW-1:0]   dep_new;
    logic [31:0]     since_sample;
    logic            sample;

    // arrival in fixed point, limited to the largest departure time
    assign arr_ext = MW'(arr_reg) << FRAC_BITS;
    assign arr_fx  = (arr_ext > MW'(DEP_MAX)) ? DEP_MAX : DW'(arr_ext);

    assign dtail_sum = (QCW+1)'(dhead_reg) + (QCW+1)'(dcount_reg);
    assign dtail     = (dtail_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
                       QAW'(dtail_sum - (QCW+1)'(QUEUE_DEPTH)) : QAW'(dtail_sum);
    assign wtail_sum = (WCW+1)'(whead_reg) + (WCW+1)'(wcount_reg);
    assign wtail     = (wtail_sum >= (WCW+1)'(WINDOW_DEPTH)) ?
                       WAW'(wtail_sum - (WCW+1)'(WINDOW_DEPTH)) : WAW'(wtail_sum);

    assign cap_eff = (16'(cfg.capacity_in_use) > 16'(QUEUE_DEPTH)) ?
                     16'(QUEUE_DEPTH) : 16'(cfg.capacity_in_use);
    assign lim_eff = (16'(cfg.window_limit) > 16'(WINDOW_DEPTH)) ?
                     16'(WINDOW_DEPTH) : 16'(cfg.window_limit);
    assign full    = (16'(dcount_reg) >= cap_eff);
    assign room    = (16'(wcount_reg) < lim_eff);

    assign win_edge = arr_reg - cfg.window_length;

    assign base    = ((dcount_reg != '0) && (last_dep_reg > arr_fx)) ? last_dep_reg : arr_fx;
    assign dep_sum = {1'b0, base} + (DW+1)'(dur_reg);
    assign dep_new = dep_sum[DW] ? DEP_MAX : dep_sum[DW-1:0];

    assign since_sample = arr_reg - last_sample_reg;
    assign sample       = first_reg || (since_sample >= cfg.sample_interval);

    psw_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_dep_ram (
        .clk     (clk),
        .wr_en   (dep_we),
        .wr_addr (dtail),
        .wr_data (dep_new),
        .rd_addr (dhead_reg),
        .rd_data (dep_rd)
    );

    psw_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_win_ram (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (wtail),
        .wr_data (arr_reg),
        .rd_addr (whead_reg),
        .rd_data (win_rd)
    );

    assign res_out.valid             = out_valid_reg;
    assign res_out.verdict           = o_verdict_reg;
    assign res_out.accepted_total    = o_acc_reg;
    assign res_out.full_reject_total = o_full_reg;
    assign res_out.rate_reject_total = o_rate_reg;
    assign res_out.occupancy         = o_occ_reg;
    assign res_out.sample_taken      = o_sample_reg;

    always_comb
    begin
        state_next       = state_reg;
        arr_next         = arr_reg;
        dur_next         = dur_reg;
        dhead_next       = dhead_reg;
        dcount_next      = dcount_reg;
        last_dep_next    = last_dep_reg;
        whead_next       = whead_reg;
        wcount_next      = wcount_reg;
        acc_next         = acc_reg;
        fullc_next       = fullc_reg;
        ratec_next       = ratec_reg;
        last_sample_next = last_sample_reg;
        first_next       = first_reg;
        verdict_next     = verdict_reg;
        out_valid_next   = out_valid_reg;
        o_verdict_next   = o_verdict_reg;
        o_acc_next       = o_acc_reg;
        o_full_next      = o_full_reg;
        o_rate_next      = o_rate_reg;
        o_occ_next       = o_occ_reg;
        o_sample_next    = o_sample_reg;
        fifo_pop         = 1'b0;
        dep_we           = 1'b0;
        win_we           = 1'b0;

        if (out_valid_reg && res_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (fifo_nonempty)
                begin
                    fifo_pop   = 1'b1;
                    arr_next   = item_arrival;
                    dur_next   = item_duration;
                    state_next = B_DREAD;
                end
            end
            B_DREAD: state_next = B_DCMP;
            B_DCMP:
            begin
                // drop departures that are due by the arrival, one per pass
                if ((dcount_reg != '0) && (dep_rd <= arr_fx))
                begin
                    dhead_next  = (dhead_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : dhead_reg + 1'b1;
                    dcount_next = dcount_reg - 1'b1;
                    state_next  = B_DREAD;
                end
                else if (full)
                begin
                    fullc_next   = (fullc_reg == '1) ? fullc_reg : fullc_reg + 32'd1;
                    verdict_next = VERDICT_FULL;
                    state_next   = B_EMIT;
                end
                else
                begin
                    state_next = B_WREAD;
                end
            end
            B_WREAD: state_next = B_WCMP;
            B_WCMP:
            begin
                if ((wcount_reg != '0) && ($signed(win_rd) <= $signed(win_edge)))
                begin
                    whead_next  = (whead_reg == WAW'(WINDOW_DEPTH - 1)) ? '0 : whead_reg + 1'b1;
                    wcount_next = wcount_reg - 1'b1;
                    state_next  = B_WREAD;
                end
                else if (room)
                begin
                    dep_we        = 1'b1;
                    win_we        = 1'b1;
                    dcount_next   = dcount_reg + 1'b1;
                    wcount_next   = wcount_reg + 1'b1;
                    last_dep_next = dep_new;
                    acc_next      = (acc_reg == '1) ? acc_reg : acc_reg + 32'd1;
                    verdict_next  = VERDICT_ACCEPT;
                    state_next    = B_EMIT;
                end
                else
                begin
                    ratec_next   = (ratec_reg == '1) ? ratec_reg : ratec_reg + 32'd1;
                    verdict_next = VERDICT_RATE;
                    state_next   = B_EMIT;
                end
            end
            B_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || res_out.ready)
                begin
                    out_valid_next = 1'b1;
                    o_verdict_next = verdict_reg;
                    o_acc_next     = acc_reg;
                    o_full_next    = fullc_reg;
                    o_rate_next    = ratec_reg;
                    o_occ_next     = 7'(dcount_reg);
                    o_sample_next  = sample;
                    if (sample)
                    begin
                        last_sample_next = arr_reg;
                        first_next       = 1'b0;
                    end
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            dhead_reg       <= '0;
            dcount_reg      <= '0;
            last_dep_reg    <= '0;
            whead_reg       <= '0;
            wcount_reg      <= '0;
            acc_reg         <= '0;
            fullc_reg       <= '0;
            ratec_reg       <= '0;
            last_sample_reg <= '0;
            first_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dhead_reg       <= dhead_next;
            dcount_reg      <= dcount_next;
            last_dep_reg    <= last_dep_next;
            whead_reg       <= whead_next;
            wcount_reg      <= wcount_next;
            acc_reg         <= acc_next;
            fullc_reg       <= fullc_next;
            ratec_reg       <= ratec_next;
            last_sample_reg <= last_sample_next;
            first_reg       <= first_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg       <= arr_next;
        dur_reg       <= dur_next;
        verdict_reg   <= verdict_next;
        o_verdict_reg <= o_verdict_next;
        o_acc_reg     <= o_acc_next;
        o_full_reg    <= o_full_next;
        o_rate_reg    <= o_rate_next;
        o_occ_reg     <= o_occ_next;
        o_sample_reg  <= o_sample_next;
    end
endmodule

// ===== hdl/packet_shaper_window_policer.sv =====
// Channel    Role   Fields
// pkt_in     sink   arrival_time[31:0], packet_bytes[15:0]
// res_out    source verdict, accepted/full_reject/rate_reject totals, occupancy, sample_taken
// apb        slave  5 registers at byte address 4*i
//
// Front: serial divider of 16+FRAC_BITS quotient bits between an accept state and a push
// state that waits while the queue is full. Back: pop, then read and compare the departure
// queue, then, unless rejected as queue-full, read and compare the window, then emit; each
// purged departure and purged window entry repeats its read (one RAM read each), and emit
// waits out output stalls. The front takes a new request only after pushing the last one.
// A two-entry queue between front and back lets the divider run ahead of the purges.
// Reset clears all control state; queue RAMs need no clearing.
module packet_shaper_window_policer
    import psw_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int WINDOW_DEPTH = 64,
    parameter int FRAC_BITS    = 16,
    parameter int TIME_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    psw_in_if.sink      pkt_in,
    psw_out_if.source   res_out
);
    localparam int DIVW = 16 + FRAC_BITS;

    logic [6:0]      cap_reg;
    logic [31:0]     wlen_reg;
    logic [6:0]      wlim_reg;
    logic [15:0]     rate_reg;
    logic [31:0]     sint_reg;
    reg_index_t      reg_sel;
    cfg_t            cfg;

    logic            push;
    logic [31:0]     f_arrival;
    logic [DIVW-1:0] f_duration;
    logic            fifo_full, fifo_nonempty, fifo_pop;
    logic [32+DIVW-1:0] fifo_out;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[4:2]);

    always_comb
    begin
        case (reg_sel)
            REG_CAPACITY:      prdata = 32'(cap_reg);
            REG_WINDOW_LENGTH: prdata = wlen_reg;
            REG_WINDOW_LIMIT:  prdata = 32'(wlim_reg);
            REG_DRAIN_RATE:    prdata = 32'(rate_reg);
            REG_SAMPLE_INT:    prdata = sint_reg;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= RST_CAPACITY;
            wlen_reg <= RST_WINDOW_LEN;
            wlim_reg <= RST_WINDOW_LIMIT;
            rate_reg <= RST_DRAIN_RATE;
            sint_reg <= RST_SAMPLE_INT;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_CAPACITY:      cap_reg  <= pwdata[6:0];
                REG_WINDOW_LENGTH: wlen_reg <= pwdata;
                REG_WINDOW_LIMIT:  wlim_reg <= pwdata[6:0];
                REG_DRAIN_RATE:    rate_reg <= pwdata[15:0];
                REG_SAMPLE_INT:    sint_reg <= pwdata;
                default:           cap_reg  <= cap_reg;
            endcase
        end
    end

    assign cfg.capacity_in_use = cap_reg;
    assign cfg.window_length   = wlen_reg;
    assign cfg.window_limit    = wlim_reg;
    assign cfg.sample_interval = sint_reg;

    psw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .drain_rate (rate_reg),
        .pkt_in     (pkt_in),
        .push       (push),
        .arrival    (f_arrival),
        .duration   (f_duration),
        .fifo_full  (fifo_full)
    );

    psw_fifo #(.WIDTH(32 + DIVW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_arrival, f_duration}),
        .full      (fifo_full),
        .nonempty  (fifo_nonempty),
        .pop       (fifo_pop),
        .pop_data  (fifo_out)
    );

    psw_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FRAC_BITS    (FRAC_BITS),
        .TIME_BITS    (TIME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .fifo_nonempty (fifo_nonempty),
        .item_arrival  (fifo_out[32+DIVW-1:DIVW]),
        .item_duration (fifo_out[DIVW-1:0]),
        .fifo_pop      (fifo_pop),
        .res_out       (res_out)
    );
endmodule

// ===== hdl/psw_checker.sv =====
module psw_checker
    import psw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  verdict,
    input logic [31:0] accepted_total,
    input logic [31:0] full_reject_total,
    input logic [6:0]  occupancy
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("result dropped while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict != 2'd3)
        else $error("undefined verdict code");

    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_ACCEPT |-> accepted_total != 32'd0 && occupancy != 7'd0)
        else $error("accepted request not counted or not queued");

    a_full_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_FULL |-> full_reject_total != 32'd0)
        else $error("full reject not counted");
endmodule

bind packet_shaper_window_policer psw_checker u_psw_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (res_out.valid),
    .out_ready         (res_out.ready),
    .verdict           (res_out.verdict),
    .accepted_total    (res_out.accepted_total),
    .full_reject_total (res_out.full_reject_total),
    .occupancy         (res_out.occupancy)
);
